// ----- rtl/core/shsd_pkg.sv -----
// shared types, constants and the half-step coil table for the stepper sequencer
`default_nettype none

package shsd_pkg;

   // field widths
   localparam int SPR_W      = 16;
   localparam int PERIOD_W   = 24;
   localparam int COUNT_W    = 32;
   localparam int POS_W      = 16;
   localparam int COIL_W     = 4;
   localparam int FUNC_W     = 2;
   localparam int SEQ_IDX_W  = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // item function codes
   localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_MOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_STOP = 2'd2;

   // register indexes (word address bit selects)
   localparam logic REG_STEPS_PER_REV = 1'b0;
   localparam logic REG_STEP_PERIOD   = 1'b1;

   // register reset values
   localparam logic [SPR_W-1:0]    SPR_RESET    = 16'd4096;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd977;
   localparam logic [PERIOD_W-1:0] TICK_MAX     = {PERIOD_W{1'b1}};

   // one input beat
   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [COUNT_W-1:0] step_count;
      logic               forward;
   } item_type;

   // one result beat
   typedef struct packed {
      logic [COIL_W-1:0] coils;
      logic              busy_res;
      logic [POS_W-1:0]  position;
      logic              stepped;
   } result_type;

   // sequencer state carried from item to item
   typedef struct packed {
      logic [POS_W-1:0]    rotor_position;
      logic [COUNT_W-1:0]  steps_remaining;
      logic [PERIOD_W-1:0] elapsed_ticks;
      logic                move_forward;
      logic [COIL_W-1:0]   coil_state;
   } state_type;

   // configuration registers
   typedef struct packed {
      logic [SPR_W-1:0]    steps_per_rev;
      logic [PERIOD_W-1:0] step_period;
   } cfg_type;

   // half-step coil pattern for position mod 8
   function automatic logic [COIL_W-1:0] half_step_coils(input logic [SEQ_IDX_W-1:0] idx);
      logic [COIL_W-1:0] pat;
      unique case (idx)
         3'd0:    pat = 4'd1;
         3'd1:    pat = 4'd3;
         3'd2:    pat = 4'd2;
         3'd3:    pat = 4'd6;
         3'd4:    pat = 4'd4;
         3'd5:    pat = 4'd12;
         3'd6:    pat = 4'd8;
         3'd7:    pat = 4'd9;
         default: pat = 4'd0;
      endcase
      return pat;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/shsd_channels.sv -----
// valid/ready channel interfaces for command beats and result beats
`default_nettype none

interface shsd_req_if;
   logic                        valid;
   logic                        ready;
   logic [shsd_pkg::FUNC_W-1:0]  func;
   logic [shsd_pkg::COUNT_W-1:0] step_count;
   logic                        forward;

   modport source (output valid, func, step_count, forward, input ready);
   modport sink   (input valid, func, step_count, forward, output ready);
endinterface

interface shsd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [shsd_pkg::COIL_W-1:0] coils;
   logic                       busy_res;
   logic [shsd_pkg::POS_W-1:0]  position;
   logic                       stepped;

   modport source (output valid, coils, busy_res, position, stepped, input ready);
   modport sink   (input valid, coils, busy_res, position, stepped, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/shsd_step_calc.sv -----
// next-state and result logic for one tick, move or stop beat
`default_nettype none

module shsd_step_calc (
   input  shsd_pkg::cfg_type    cfg,
   input  shsd_pkg::state_type  cur,
   input  shsd_pkg::item_type   item,
   output shsd_pkg::state_type  nxt,
   output shsd_pkg::result_type res
);
   import shsd_pkg::*;

   logic [PERIOD_W-1:0] ticks_sat;
   logic [POS_W:0]      wrap_pt;
   logic [POS_W:0]      pos_up;
   logic [POS_W:0]      wrap_last;
   logic [POS_W-1:0]    pos_step;
   logic                step_due;

   // saturating tick count
   assign ticks_sat = (cur.elapsed_ticks == TICK_MAX) ? cur.elapsed_ticks
                                                      : cur.elapsed_ticks + 1'b1;

   // wrap point, zero meaning a full 16-bit revolution
   assign wrap_pt   = (cfg.steps_per_rev == '0) ? {1'b1, {POS_W{1'b0}}}
                                                : {1'b0, cfg.steps_per_rev};
   assign pos_up    = {1'b0, cur.rotor_position} + 1'b1;
   assign wrap_last = wrap_pt - 1'b1;

   // position after one step in the current direction
   always_comb begin
      if (cur.move_forward) begin
         pos_step = (pos_up >= wrap_pt) ? '0 : pos_up[POS_W-1:0];
      end else if (cur.rotor_position == '0 || {1'b0, cur.rotor_position} >= wrap_pt) begin
         pos_step = wrap_last[POS_W-1:0];
      end else begin
         pos_step = cur.rotor_position - 1'b1;
      end
   end

   assign step_due = (cur.steps_remaining != '0) && (ticks_sat >= cfg.step_period);

   // state update per function code
   always_comb begin
      nxt         = cur;
      res.stepped = 1'b0;
      unique case (item.func)
         FUNC_TICK: begin
            nxt.elapsed_ticks = ticks_sat;
            if (step_due) begin
               nxt.elapsed_ticks   = '0;
               nxt.rotor_position  = pos_step;
               nxt.coil_state      = half_step_coils(pos_step[SEQ_IDX_W-1:0]);
               nxt.steps_remaining = cur.steps_remaining - 1'b1;
               res.stepped         = 1'b1;
            end
         end
         FUNC_MOVE: begin
            nxt.steps_remaining = item.step_count;
            nxt.move_forward    = item.forward;
         end
         FUNC_STOP: begin
            nxt.coil_state      = '0;
            nxt.steps_remaining = '0;
         end
         default: begin
            nxt = cur;
         end
      endcase
      res.coils    = nxt.coil_state;
      res.busy_res = (nxt.steps_remaining != '0);
      res.position = nxt.rotor_position;
   end

endmodule

`default_nettype wire

// ----- rtl/core/stepper_half_step_driver_unit.sv -----
// top level of the half-step stepper sequencer: channels, registers, state
//
// Command beats arrive on req_chan: a microsecond tick, a move (step count and
// direction) or a stop. Every command beat gives exactly one result beat on
// rsp_chan with the coil drive bits, the busy flag, the position and whether
// that beat made a step. Two registers (steps per revolution at byte 0, step
// period at byte 4) are written and read over the APB-style port; pready is
// always high, and writes are meant for idle periods only.
// A beat in the input register is worked out against the stored state by
// combinational logic and its result goes into the result register when it
// can load. Throughput is one beat per clock while the receiver takes results,
// set by the single state update between the input and result registers.
// Reset (synchronous, active high) clears position, remaining steps, tick
// counter and direction, turns all coils off, empties both stages and loads
// 4096 steps per revolution and a period of 977 ticks.
// When the receiver stalls the result register holds; the input register
// still takes one more beat, then req_chan.ready drops until results move.
`default_nettype none

module stepper_half_step_driver_unit (
   input  logic                               clock,
   input  logic                               reset,
   shsd_req_if.sink                           req_chan,
   shsd_rsp_if.source                         rsp_chan,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [shsd_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [shsd_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [shsd_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);
   import shsd_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   item_type   item_ff;
   logic       in_valid_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type result_ff;
   result_type result_in;
   logic       out_valid_ff;
   logic       in_take;
   logic       out_load;
   logic       csr_write;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_STEPS_PER_REV: cfg_in.steps_per_rev = pwdata[SPR_W-1:0];
            REG_STEP_PERIOD:   cfg_in.step_period   = pwdata[PERIOD_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_STEPS_PER_REV: prdata = {{(CSR_DATA_W-SPR_W){1'b0}}, cfg_ff.steps_per_rev};
         REG_STEP_PERIOD:   prdata = {{(CSR_DATA_W-PERIOD_W){1'b0}}, cfg_ff.step_period};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.steps_per_rev <= SPR_RESET;
         cfg_ff.step_period   <= PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stage handshakes
   assign out_load       = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || out_load;
   assign in_take        = req_chan.valid && req_chan.ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         item_ff.func       <= req_chan.func;
         item_ff.step_count <= req_chan.step_count;
         item_ff.forward    <= req_chan.forward;
      end
   end

   // state update for the registered beat
   shsd_step_calc u_calc (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (item_ff),
      .nxt  (state_in),
      .res  (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (out_load) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.coils    = result_ff.coils;
   assign rsp_chan.busy_res = result_ff.busy_res;
   assign rsp_chan.position = result_ff.position;
   assign rsp_chan.stepped  = result_ff.stepped;

`ifndef NO_ASSERTIONS
   // a step always energises some coil
   a_step_coils_on: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && result_ff.stepped |-> result_ff.coils != '0)
      else $error("step result with all coils off");

   // the tick counter restarts after a step
   a_step_clears_ticks: assert property (@(posedge clock) disable iff (reset)
      out_load && result_in.stepped |=> state_ff.elapsed_ticks == '0)
      else $error("tick counter not cleared after step");

   // busy flag follows the stored remaining count
   a_busy_matches: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_chan.busy_res == (state_ff.steps_remaining != '0))
      else $error("busy flag disagrees with remaining steps");

   // stop leaves coils off and nothing to do
   a_stop_idles: assert property (@(posedge clock) disable iff (reset)
      out_load && item_ff.func == FUNC_STOP
      |=> state_ff.coil_state == '0 && state_ff.steps_remaining == '0)
      else $error("stop did not de-energise");
`endif

endmodule

`default_nettype wire
